@@ hw/rtl/arpc_pkg.sv @@
// Package: shared types, codes and constants for the ARP responder with cache.
package arpc_pkg;

  // request codes
  localparam logic [1:0] REQ_PKT    = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_ANSWER  = 2'd1;
  localparam logic [1:0] ST_REPLY   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [1:0] CFG_OWN_MAC = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // header checks
  localparam logic [10:0] MIN_LEN    = 11'd28;
  localparam logic [15:0] HW_ETHER   = 16'd1;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [7:0]  HW_LEN     = 8'd6;
  localparam logic [7:0]  PROTO_LEN  = 8'd4;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd60;
  localparam int unsigned ENTRY_W = 32 + 48 + 32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] packet_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] opcode;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] lookup_ip;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        reply_valid;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic chk;
    logic wr;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic start_scan;
    logic store_req;
    logic scan_end;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/arp_responder_with_cache.sv @@
// Top level: ARP responder with address cache, controller plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data    (arpc_pkg::in_t)
//  out     | output    | out_valid / out_ready| out_data   (arpc_pkg::out_t)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. A scan reads one table entry at a time, a read and then
// a check, from the single read port of the table RAM: a packet or lookup
// scan stops at a match or after ENTRIES entries, a packet that stores adds
// a table write, a tick always reads all ENTRIES, items without a scan skip it.
// Reset clears the valid bits at once; no clearing pass. A stalled result is
// held in the output register; the next item is accepted and worked on, and
// waits for the register only at its end. Configuration is always ready.
module arp_responder_with_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  arpc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output arpc_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [47:0]     cfg_data
);

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arpc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ hw/rtl/arpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/arpc_ctrl.sv @@
// Controller: sequences accept, table scan, table write and result hand-off.
module arpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arpc_pkg::sts_t    sts,
  output arpc_pkg::cmd_t    cmd
);

  arpc_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arpc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.start_scan ? arpc_pkg::S_RD : arpc_pkg::S_DONE;
        end
      end
      arpc_pkg::S_RD: state_nxt = arpc_pkg::S_CHK;
      arpc_pkg::S_CHK: begin
        if (sts.scan_end) begin
          state_nxt = sts.store_req ? arpc_pkg::S_WR : arpc_pkg::S_DONE;
        end else begin
          state_nxt = arpc_pkg::S_RD;
        end
      end
      arpc_pkg::S_WR: state_nxt = arpc_pkg::S_DONE;
      arpc_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = arpc_pkg::S_IDLE;
        end
      end
      default: state_nxt = arpc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      arpc_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      arpc_pkg::S_RD:   cmd.rd   = 1'b1;
      arpc_pkg::S_CHK:  cmd.chk  = 1'b1;
      arpc_pkg::S_WR:   cmd.wr   = 1'b1;
      arpc_pkg::S_DONE: cmd.load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_rd_then_chk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arpc_pkg::S_RD |=> state_r == arpc_pkg::S_CHK)
    else $error("read not followed by check");
  a_wr_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arpc_pkg::S_WR |-> $past(state_r) == arpc_pkg::S_CHK)
    else $error("table write without finished scan");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !sts.out_busy)
    else $error("result loaded over a pending result");
`endif

endmodule

@@ hw/rtl/arpc_dp.sv @@
// Datapath: config registers, item register, cache table, scan logic, result register.
module arpc_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  arpc_pkg::in_t     in_data,
  output arpc_pkg::out_t    out_data,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_data,
  input  arpc_pkg::cmd_t    cmd,
  output arpc_pkg::sts_t    sts
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned EW = arpc_pkg::ENTRY_W;

  logic [31:0]        own_ip_r;
  logic [15:0]        timeout_r;
  logic [31:0]        time_r, time_nxt;
  arpc_pkg::in_t      item_r;
  logic               store_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0]      idx_r, match_r, free_r, old_r;
  logic               found_r, free_ok_r;
  logic [31:0]        best_r;
  arpc_pkg::out_t     res_r, res_nxt, out_r;
  logic               out_valid_r;

  logic               hdr_ok, store_in;
  logic [EW-1:0]      rdata;
  logic [31:0]        e_ip, e_stamp, age, key;
  logic [47:0]        e_mac;
  logic               e_valid, e_exp, hit, last;
  logic [IW-1:0]      slot;

  // check the header of the offered item
  assign hdr_ok = (in_data.packet_length >= arpc_pkg::MIN_LEN) &&
                  (in_data.hw_type == arpc_pkg::HW_ETHER) &&
                  (in_data.proto_type == arpc_pkg::PROTO_IPV4) &&
                  (in_data.hw_addr_len == arpc_pkg::HW_LEN) &&
                  (in_data.proto_addr_len == arpc_pkg::PROTO_LEN);
  assign store_in = (in_data.req_type == arpc_pkg::REQ_PKT) && hdr_ok &&
                    (in_data.src_ip != 32'd0);

  // decode the entry read in the previous cycle
  assign e_ip    = rdata[EW-1 -: 32];
  assign e_mac   = rdata[EW-33 -: 48];
  assign e_stamp = rdata[31:0];
  assign age     = time_r - e_stamp;
  assign e_exp   = age > {16'd0, timeout_r};
  assign e_valid = valid_r[idx_r];
  assign key     = (item_r.req_type == arpc_pkg::REQ_PKT) ? item_r.src_ip
                                                          : item_r.lookup_ip;
  assign hit     = e_valid && (e_ip == key) &&
                   ((item_r.req_type == arpc_pkg::REQ_PKT) ||
                    (item_r.req_type == arpc_pkg::REQ_LOOKUP));
  assign last    = idx_r == IW'(ENTRIES - 1);
  assign slot    = found_r ? match_r : (free_ok_r ? free_r : old_r);

  assign sts.start_scan = store_in || (in_data.req_type == arpc_pkg::REQ_LOOKUP) ||
                          (in_data.req_type == arpc_pkg::REQ_TICK);
  assign sts.store_req  = store_r;
  assign sts.scan_end   = hit || last;
  assign sts.out_busy   = out_valid_r && !out_ready;

  arpc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (slot),
    .wdata ({item_r.src_ip, item_r.src_mac, time_r}),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // configuration registers; own_mac only sources replies' sender field,
  // which is built downstream, so its writes are dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= 32'd0;
      timeout_r <= arpc_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        arpc_pkg::CFG_OWN_IP:  own_ip_r  <= cfg_data[31:0];
        arpc_pkg::CFG_TIMEOUT: timeout_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // advance time on an accepted tick
  always_comb begin
    time_nxt = time_r;
    if (cmd.accept && in_data.req_type == arpc_pkg::REQ_TICK) begin
      time_nxt = time_r + 32'd1;
    end
  end

  // valid bits: drop expired entries seen by a tick scan or hit by a lookup, set the written slot
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.chk && e_valid && e_exp &&
        ((item_r.req_type == arpc_pkg::REQ_TICK) ||
         (item_r.req_type == arpc_pkg::REQ_LOOKUP && hit))) begin
      valid_nxt[idx_r] = 1'b0;
    end
    if (cmd.wr) begin
      valid_nxt[slot] = 1'b1;
    end
  end

  // result under construction
  always_comb begin
    res_nxt = res_r;
    if (cmd.accept) begin
      res_nxt = '0;
      if (in_data.req_type == arpc_pkg::REQ_PKT && hdr_ok) begin
        if (in_data.opcode == arpc_pkg::OP_REQUEST && in_data.dst_ip == own_ip_r) begin
          res_nxt.status           = arpc_pkg::ST_ANSWER;
          res_nxt.reply_valid      = 1'b1;
          res_nxt.reply_target_mac = in_data.src_mac;
          res_nxt.reply_target_ip  = in_data.src_ip;
        end else if (in_data.opcode == arpc_pkg::OP_REPLY) begin
          res_nxt.status = arpc_pkg::ST_REPLY;
        end
      end
    end else if (cmd.chk && hit && !e_exp && item_r.req_type == arpc_pkg::REQ_LOOKUP) begin
      res_nxt.lookup_hit = 1'b1;
      res_nxt.lookup_mac = e_mac;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= 32'd0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      time_r  <= time_nxt;
      valid_r <= valid_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, scan trackers and result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.load) begin
      out_r <= res_r;
    end
    if (cmd.accept) begin
      item_r    <= in_data;
      store_r   <= store_in;
      idx_r     <= '0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.chk) begin
      if (!(hit || last)) begin
        idx_r <= idx_r + IW'(1);
      end
      if (hit) begin
        found_r <= 1'b1;
        match_r <= idx_r;
      end
      if (!e_valid && !free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r    <= idx_r;
      end
      if (idx_r == '0 || age > best_r) begin
        best_r <= age;
        old_r  <= idx_r;
      end
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule
